/* rtl/core/rational_arithmetic_unit_core_defines.svh */
// Assertion macros for the rational arithmetic unit.
// No dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/core/rau_pkg.sv */
// Package for the rational arithmetic unit: word width, opcodes, states, divider I/O.
// No dependencies.
package rau_pkg;
    localparam int WORD_BITS = 32;
    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    typedef logic [WORD_BITS-1:0] word_t;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_COMB, ST_GCD_CHK, ST_GCD_WAIT,
        ST_QN_WAIT, ST_QD_WAIT, ST_DONE
    } state_t;

    typedef struct packed {
        logic  start;
        logic  want_quot;
        word_t a;
        word_t b;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t result;
    } div_rsp_t;

    function automatic word_t w_sext32(input logic [31:0] v);
        return word_t'($signed(v));
    endfunction

    function automatic logic [31:0] w_to32(input word_t v);
        return 32'($signed(v));
    endfunction
endpackage

/* rtl/core/rational_arithmetic_unit_core.sv */
// Sequence from input transfer to result valid: MUL1, MUL2, COMB, Euclid remainder steps
// (GCD_CHK/GCD_WAIT), the two quotients (QN_WAIT, QD_WAIT), DONE; an item flagged in error
// before reduction goes from COMB straight to DONE. One item at a time: in_stall is high
// from acceptance until the result transfer. The shared bit-serial divider sets the rate.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle, output empty.
module rational_arithmetic_unit_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic signed [1:0]  cmp_sign,
    output logic        status
);
    localparam int W = rau_pkg::WORD_BITS;

    rau_pkg::state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;
    rau_pkg::word_t an_reg, an_next, ad_reg, ad_next, bn_reg, bn_next, bd_reg, bd_next;
    rau_pkg::word_t p_reg, p_next, q_reg, q_next;
    rau_pkg::word_t ga_reg, ga_next, gb_reg, gb_next, qn_reg, qn_next;
    logic err_reg, err_next;
    logic ov_reg, ov_next;
    logic [31:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [1:0] cs_reg, cs_next;
    logic st_reg, st_next;
    rau_pkg::div_req_t dreq;
    rau_pkg::div_rsp_t drsp;
    rau_pkg::word_t rn_w, rd_w, qd_w;
    logic in_xfer;

    rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_xfer = in_valid && !in_stall;
    assign in_stall = (state_reg != rau_pkg::ST_IDLE) || ov_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        p_next = p_reg; q_next = q_reg;
        ga_next = ga_reg; gb_next = gb_reg; qn_next = qn_reg;
        err_next = err_reg;
        ov_next = ov_reg && out_stall;
        rn_next = rn_reg; rd_next = rd_reg; cs_next = cs_reg; st_next = st_reg;
        dreq.start = 1'b0;
        dreq.want_quot = 1'b0;
        dreq.a = ga_reg;
        dreq.b = gb_reg;
        rn_w = '0; rd_w = '0;
        qd_w = drsp.result;
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next = opcode;
                    an_next = rau_pkg::w_sext32(a_num);
                    ad_next = rau_pkg::w_sext32(a_den);
                    bn_next = rau_pkg::w_sext32(b_num);
                    bd_next = rau_pkg::w_sext32(b_den);
                    state_next = rau_pkg::ST_MUL1;
                end
            end
            rau_pkg::ST_MUL1:
            begin
                err_next = (op_reg > rau_pkg::OP_CMP) || (ad_reg == '0) || (bd_reg == '0)
                    || (op_reg == rau_pkg::OP_DIV && bn_reg == '0);
                p_next = W'(an_reg * bd_reg);
                q_next = (op_reg == rau_pkg::OP_DIV) ? W'(ad_reg * bn_reg)
                                                     : W'(ad_reg * bd_reg);
                state_next = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2:
            begin
                ga_next = q_reg;
                gb_next = (op_reg == rau_pkg::OP_MUL) ? W'(an_reg * bn_reg)
                                                      : W'(bn_reg * ad_reg);
                state_next = rau_pkg::ST_COMB;
            end
            rau_pkg::ST_COMB:
            begin
                case (op_reg)
                    rau_pkg::OP_ADD: rn_w = p_reg + gb_reg;
                    rau_pkg::OP_SUB, rau_pkg::OP_CMP: rn_w = p_reg - gb_reg;
                    rau_pkg::OP_MUL: rn_w = gb_reg;
                    default: rn_w = p_reg;
                endcase
                p_next = rn_w;
                gb_next = rn_w;
                state_next = err_reg ? rau_pkg::ST_DONE : rau_pkg::ST_GCD_CHK;
            end
            rau_pkg::ST_GCD_CHK:
            begin
                if (gb_reg == '0)
                begin
                    if (ga_reg == '0)
                    begin
                        err_next = 1'b1;
                        state_next = rau_pkg::ST_DONE;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        dreq.want_quot = 1'b1;
                        dreq.a = p_reg;
                        dreq.b = ga_reg;
                        state_next = rau_pkg::ST_QN_WAIT;
                    end
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = rau_pkg::ST_GCD_WAIT;
                end
            end
            rau_pkg::ST_GCD_WAIT:
            begin
                if (drsp.done)
                begin
                    ga_next = gb_reg;
                    gb_next = drsp.result;
                    state_next = rau_pkg::ST_GCD_CHK;
                end
            end
            rau_pkg::ST_QN_WAIT:
            begin
                dreq.a = q_reg;
                dreq.b = ga_reg;
                if (drsp.done)
                begin
                    qn_next = drsp.result;
                    dreq.start = 1'b1;
                    dreq.want_quot = 1'b1;
                    state_next = rau_pkg::ST_QD_WAIT;
                end
            end
            rau_pkg::ST_QD_WAIT:
            begin
                if (drsp.done)
                begin
                    rd_w = qd_w;
                    if (rd_w == '0)
                        err_next = 1'b1;
                    else
                    begin
                        rn_next = rau_pkg::w_to32(qn_reg);
                        rd_next = rau_pkg::w_to32(rd_w);
                    end
                    q_next = rd_w;
                    state_next = rau_pkg::ST_DONE;
                end
            end
            rau_pkg::ST_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    st_next = err_reg;
                    cs_next = 2'b00;
                    if (err_reg || op_reg == rau_pkg::OP_CMP)
                    begin
                        rn_next = '0;
                        rd_next = 32'd1;
                    end
                    if (!err_reg && op_reg == rau_pkg::OP_CMP && qn_reg != '0)
                        cs_next = (qn_reg[W-1] == q_reg[W-1]) ? 2'b01 : 2'b11;
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        an_reg <= an_next; ad_reg <= ad_next; bn_reg <= bn_next; bd_reg <= bd_next;
        p_reg <= p_next; q_reg <= q_next;
        ga_reg <= ga_next; gb_reg <= gb_next; qn_reg <= qn_next;
        err_reg <= err_next;
        rn_reg <= rn_next; rd_reg <= rd_next; cs_reg <= cs_next; st_reg <= st_next;
    end

    assign out_valid = ov_reg;
    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign cmp_sign = cs_reg;
    assign status = st_reg;
endmodule

/* rtl/core/rau_divider.sv */
// Iterative restoring divider, one quotient bit per cycle, truncating signed semantics.
// Depends on rau_pkg.
module rau_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    localparam int W = rau_pkg::WORD_BITS;

    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic [rau_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic neg_q_reg, neg_q_next, neg_r_reg, neg_r_next, quot_reg, quot_next;
    logic [W:0] trial;
    logic [W-1:0] shifted;
    logic [W-1:0] mag_a, mag_b;

    always_comb
    begin
        mag_a = req.a[W-1] ? (W'(0) - req.a) : req.a;
        mag_b = req.b[W-1] ? (W'(0) - req.b) : req.b;
        shifted = {rem_reg[W-2:0], quo_reg[W-1]};
        trial = {1'b0, shifted} - {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        quot_next = quot_reg;
        if (req.start && !busy_reg)
        begin
            rem_next = '0;
            quo_next = mag_a;
            dvs_next = mag_b;
            cnt_next = rau_pkg::CNT_BITS'(W);
            busy_next = 1'b1;
            neg_q_next = req.a[W-1] ^ req.b[W-1];
            neg_r_next = req.a[W-1];
            quot_next = req.want_quot;
        end
        else if (busy_reg)
        begin
            if (trial[W])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rau_pkg::CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        quot_reg <= quot_next;
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (quot_reg)
            rsp.result = neg_q_reg ? (W'(0) - quo_reg) : quo_reg;
        else
            rsp.result = neg_r_reg ? (W'(0) - rem_reg) : rem_reg;
    end
endmodule

/* rtl/core/rau_checker.sv */
// Port-level checker for rational_arithmetic_unit_core, with its bind.
// Depends on rational_arithmetic_unit_core_defines.svh.
`include "rational_arithmetic_unit_core_defines.svh"
module rau_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] res_num,
    input logic [31:0] res_den,
    input logic [1:0]  cmp_sign,
    input logic        status
);
    `RAU_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall && !out_valid, "no stall after input transfer")
    `RAU_ASSERT_IMP(a_err_fields, out_valid && status, res_num == 32'd0 && res_den == 32'd1 && cmp_sign == 2'b00, "error result fields wrong")
    `RAU_ASSERT_IMP(a_sign_code, out_valid, cmp_sign != 2'b10, "bad compare code")
    `RAU_ASSERT_IMP(a_out_blocks_in, out_valid, in_stall, "input taken while result pending")
    `RAU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_num) && $stable(res_den) && $stable(cmp_sign) && $stable(status), "stalled result changed")
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .res_num(res_num),
    .res_den(res_den), .cmp_sign(cmp_sign), .status(status)
);

/* sim/tb.sv */
// Self-checking bench for rational_arithmetic_unit_core: random and directed fraction
// transfers with gcd-reduction prediction, bursty sender, patterned receiver stall.
// Depends on rau_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;
    typedef struct {
        logic [2:0]  op;
        logic [31:0] an, ad, bn, bd;
    } frac_item_t;

    typedef struct {
        logic [31:0] num, den;
        logic [1:0]  sgn;
        logic        st;
    } frac_res_t;

    localparam logic [2:0] OP_BAD5 = 3'd5;
    localparam logic [2:0] OP_BAD7 = 3'd7;
    localparam int LIMIT = 2000 * 6000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] opcode = '0;
    logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] res_num, res_den;
    logic signed [1:0] cmp_sign;
    logic status;
    logic in_stall_s = 1'b0;

    frac_item_t pending_q[$];
    frac_res_t  expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int cycles = 0;
    int gap_left = 0;
    bit stim_done = 0;

    rational_arithmetic_unit_core dut (.*);

    always #10 clk = ~clk;

    // truncating division and remainder on 32-bit two's complement
    function automatic logic [31:0] tdiv(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] trem(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, r;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        r = ma % mb;
        return a[31] ? -r : r;
    endfunction

    function automatic frac_res_t reduce_fraction(frac_item_t it);
        frac_res_t r;
        logic [31:0] rn, rd, g, x, y, t, qn, qd;
        bit err;
        r = '{num: 32'd0, den: 32'd1, sgn: 2'd0, st: 1'b0};
        err = (it.op > rau_pkg::OP_CMP) || it.ad == 0 || it.bd == 0
            || (it.op == rau_pkg::OP_DIV && it.bn == 0);
        if (!err)
        begin
            case (it.op)
                rau_pkg::OP_ADD:
                begin
                    rd = it.ad * it.bd; rn = it.an * it.bd + it.bn * it.ad;
                end
                rau_pkg::OP_MUL:
                begin
                    rd = it.ad * it.bd; rn = it.an * it.bn;
                end
                rau_pkg::OP_DIV:
                begin
                    rd = it.ad * it.bn; rn = it.an * it.bd;
                end
                default:
                begin
                    rd = it.ad * it.bd; rn = it.an * it.bd - it.bn * it.ad;
                end
            endcase
            x = rd;
            y = rn;
            while (y != 0)
            begin
                t = trem(x, y);
                x = y;
                y = t;
            end
            g = x;
            if (g == 0)
                err = 1;
            else
            begin
                qn = tdiv(rn, g);
                qd = tdiv(rd, g);
                if (qd == 0)
                    err = 1;
                else if (it.op == rau_pkg::OP_CMP)
                    r.sgn = (qn == 0) ? 2'd0 : (qn[31] == qd[31]) ? 2'd1 : 2'd3;
                else
                begin
                    r.num = qn;
                    r.den = qd;
                end
            end
        end
        if (err)
            r = '{num: 32'd0, den: 32'd1, sgn: 2'd0, st: 1'b1};
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return -$urandom_range(0, 20);
            2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            3: return $urandom_range(0, 1000) - 500;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(logic [2:0] op, logic [31:0] an, ad, bn, bd);
        frac_item_t it;
        it = '{op: op, an: an, ad: ad, bn: bn, bd: bd};
        pending_q.push_back(it);
    endtask

    initial
    begin
        logic [2:0] op;
        logic [31:0] nd1, nd2;
        add_item(rau_pkg::OP_ADD, 1, 2, 1, 3);
        add_item(rau_pkg::OP_SUB, 1, 2, 1, 2);
        add_item(rau_pkg::OP_MUL, -3, 4, 2, -9);
        add_item(rau_pkg::OP_DIV, 5, 7, 0, 3);
        add_item(rau_pkg::OP_DIV, 5, 7, -2, 3);
        add_item(rau_pkg::OP_CMP, 1, 3, 1, 2);
        add_item(rau_pkg::OP_CMP, 2, 3, 1, 2);
        add_item(rau_pkg::OP_CMP, 4, 6, 2, 3);
        add_item(rau_pkg::OP_ADD, 1, 0, 1, 2);
        add_item(rau_pkg::OP_SUB, 1, 2, 1, 0);
        add_item(rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_item(rau_pkg::OP_DIV, 32'h8000_0000, 1, 32'hFFFF_FFFF, 1);
        add_item(rau_pkg::OP_MUL, 0, 65536, 5, 65536);
        add_item(rau_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(OP_BAD5, 1, 2, 3, 4);
        add_item(OP_BAD7, 1, 2, 3, 4);
        add_item(rau_pkg::OP_CMP, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1);
        add_item(rau_pkg::OP_SUB, 0, 3, 0, 5);
        repeat (1950)
        begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
            nd1 = rand_word();
            nd2 = rand_word();
            if ($urandom_range(0, 30) == 0)
                nd1 = 0;
            add_item(op, rand_word(), nd1, ($urandom_range(0, 25) == 0) ? 32'd0 : rand_word(), nd2);
        end
        stim_done = 1;
    end

    // driver: bursts with random gaps
    always @(negedge clk)
    begin
        frac_item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_stall_s)
            begin
                if (gap_left == 0 && pending_q.size() != 0 && $urandom_range(0, 3) != 0)
                begin
                    it = pending_q.pop_front();
                    expected_q.push_back(reduce_fraction(it));
                    opcode <= it.op; a_num <= it.an; a_den <= it.ad;
                    b_num <= it.bn; b_den <= it.bd;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left == 0)
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 120);
                end
            end
            else if (!in_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() != 0)
                begin
                    it = pending_q.pop_front();
                    expected_q.push_back(reduce_fraction(it));
                    opcode <= it.op; a_num <= it.an; a_den <= it.ad;
                    b_num <= it.bn; b_den <= it.bd;
                    in_valid <= 1'b1;
                end
            end
            // receiver stall pattern
            case ((cycles / 700) % 3)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= (cycles % 37) < 20;
            endcase
        end
    end

    // stalled input seen at the rising edge
    always @(posedge clk)
        in_stall_s <= in_valid && in_stall;

    // monitor
    always @(posedge clk)
    begin
        frac_res_t e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res_num !== e.num)
                begin
                    $error("res_num expected %0d got %0d", $signed(e.num), res_num); errors++;
                end
                if (res_den !== e.den)
                begin
                    $error("res_den expected %0d got %0d", $signed(e.den), res_den); errors++;
                end
                if (cmp_sign !== e.sgn)
                begin
                    $error("cmp_sign expected %0d got %0d", $signed(e.sgn), cmp_sign); errors++;
                end
                if (status !== e.st)
                begin
                    $error("status expected %0d got %0d", e.st, status); errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
        repeat (200) @(posedge clk);
        $display("%0d fraction transfers checked: all opcodes, error cases, wrap extremes",
                 results_seen);
        if (errors == 0)
            $display("rational_arithmetic_unit_core verification clean");
        else
            $display("rational_arithmetic_unit_core verification failed");
        $finish;
    end

    initial
    begin
        wait (cycles >= LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("rational_arithmetic_unit_core verification failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rational_arithmetic_unit_core.sv
rtl/core/rau_checker.sv
sim/tb.sv
